### hdl/orbit_camera_position_core_defines.svh
// ----------------------------------------------------------------------------
// orbit_camera_position_core_defines
// Assertion macros shared by the orbit camera RTL.
// ----------------------------------------------------------------------------
`ifndef ORBIT_CAMERA_POSITION_CORE_DEFINES_SVH
`define ORBIT_CAMERA_POSITION_CORE_DEFINES_SVH

// Clocked check, masked while reset is high.
`define OCP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define OCP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ocam_pkg.sv
// ----------------------------------------------------------------------------
// ocam_pkg
// Types, constants and fixed-point helpers for the orbit camera core.
// ----------------------------------------------------------------------------
package ocam_pkg;

  localparam int ANGLE_BITS_DEF = 24;
  localparam int TRIG_BITS_DEF  = 16;

  localparam logic [31:0]        PI_HALF_Q30 = 32'd1686629713;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [3:0]         TERMS       = 4'd14;

  localparam logic signed [23:0] PITCH_RESET = 24'sd1869116;

  localparam logic [15:0]        YAW_GAIN_RST     = 16'd13351;
  localparam logic [15:0]        PITCH_GAIN_RST   = 16'd8011;
  localparam logic signed [22:0] PITCH_LOWER_RST  = -23'sd534030;
  localparam logic signed [22:0] PITCH_UPPER_RST  = 23'sd3471223;
  localparam logic [15:0]        ORBIT_RADIUS_RST = 16'd8960;
  localparam logic signed [15:0] FOCUS_LIFT_RST   = 16'sd2560;

  localparam logic OP_LOOK = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [2:0] {
    REG_YAW_GAIN     = 3'd0,
    REG_PITCH_GAIN   = 3'd1,
    REG_PITCH_LOWER  = 3'd2,
    REG_PITCH_UPPER  = 3'd3,
    REG_ORBIT_RADIUS = 3'd4,
    REG_FOCUS_LIFT   = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOOK_A,
    S_LOOK_B,
    S_LOOK_C,
    S_TX,
    S_TXW,
    S_TMUL,
    S_TDIV0,
    S_TDIV,
    S_TFIN,
    S_P1,
    S_P2,
    S_P3,
    S_P4,
    S_P5,
    S_P6,
    S_P7,
    S_P8,
    S_P9,
    S_P10,
    S_CAM,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [3:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  // Shift right by sh, rounding half away from zero.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned sh);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m   = neg ? 64'(-v) : 64'(v);
    m   = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  // Clamp a Q30 series sum to [0, 1] and round half up to tb fraction bits.
  function automatic logic [24:0] to_trig(input logic signed [33:0] v,
                                          input int unsigned tb);
    logic [33:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > ONE_Q30) begin
      c = ONE_Q30;
    end else begin
      c = v;
    end
    c = (c + (34'd1 << (29 - tb))) >> (30 - tb);
    return c[24:0];
  endfunction

endpackage

### hdl/ocam_mul.sv
// ----------------------------------------------------------------------------
// ocam_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module ocam_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### hdl/ocam_div.sv
// ----------------------------------------------------------------------------
// ocam_div
// Divides a 32-bit word by a small divisor, eight quotient bits a cycle.
// ----------------------------------------------------------------------------
`include "orbit_camera_position_core_defines.svh"

module ocam_div (
  input  logic               clk,
  input  logic               rst,
  input  ocam_pkg::div_req_t req,
  output ocam_pkg::div_rsp_t rsp
);
  import ocam_pkg::*;

  logic [31:0] quot;
  logic [3:0]  rem;
  logic [3:0]  dvsr;
  logic [1:0]  cnt;
  logic        busy;
  logic        done;
  logic [31:0] quot_next;
  logic [3:0]  rem_next;

  // restoring steps over the top byte
  always_comb begin
    logic [4:0] r5;
    quot_next = quot;
    rem_next  = rem;
    for (int i = 0; i < 8; i++) begin
      r5        = {rem_next, quot_next[31]};
      quot_next = {quot_next[30:0], (r5 >= {1'b0, dvsr})};
      rem_next  = (r5 >= {1'b0, dvsr}) ? 4'(r5 - {1'b0, dvsr}) : r5[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt  <= cnt + 2'd1;
      busy <= (cnt != 2'd3);
      done <= (cnt == 2'd3);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  assign rsp = '{done: done, quot: quot};

  `OCP_ASSERT(a_div_no_restart, clk, rst, req.start |-> !busy, "divider restarted while busy")

endmodule

### hdl/orbit_camera_position_core.sv
// ----------------------------------------------------------------------------
// orbit_camera_position_core
// Orbit camera: look items steer yaw/pitch, step items place focus and camera.
// ----------------------------------------------------------------------------
// Look word: accepted in idle, then LOOK_A, LOOK_B and LOOK_C, then loaded in S_OUT.
// Step word: series for yaw and pitch, products P1 to P10 and S_CAM, then S_OUT.
// Step cost is set by the sine/cosine series: per angle 14 terms, each a multiply,
// a divider start, a divide and the quotient take, plus setup and folding; the
// products and sums follow. A waiting result adds stalls. New words are taken in idle.
// Reset (rst, synchronous): yaw 0, pitch 1869116, points zero, regs default.
// ----------------------------------------------------------------------------
`include "orbit_camera_position_core_defines.svh"

module orbit_camera_position_core #(
  parameter int ANGLE_BITS = ocam_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_BITS  = ocam_pkg::TRIG_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  // mouse_dx[11:0] mouse_dy[23:12] target_x[55:24] target_y[87:56]
  // target_z[119:88]
  input  logic [119:0] s_tdata,
  // op[0]
  input  logic [0:0]   s_tuser,
  // stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  // yaw_out[23:0] pitch_out[47:24] camera_x[79:48] camera_y[111:80]
  // camera_z[143:112] focus_x[175:144] focus_y[207:176] focus_z[239:208]
  output logic [239:0] m_tdata,
  // APB config
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ocam_pkg::*;

  localparam int TW    = TRIG_BITS + 2;   // signed sin/cos width
  localparam int OFF_W = 50 - TRIG_BITS;  // signed offset width

  // config registers
  logic [15:0]        yaw_gain;
  logic [15:0]        pitch_gain;
  logic signed [22:0] pitch_lower;
  logic signed [22:0] pitch_upper;
  logic [15:0]        orbit_radius;
  logic signed [15:0] focus_lift;

  // architectural state
  logic [ANGLE_BITS-1:0] yaw;
  logic signed [23:0]    pitch;
  logic signed [31:0]    focus_x, focus_y, focus_z;
  logic signed [31:0]    cam_x, cam_y, cam_z;

  // work registers
  state_t             state, state_next;
  logic signed [11:0] dx, dy;
  logic               angle_sel;   // 0 yaw, 1 pitch
  logic [1:0]         quad;
  logic [31:0]        xq;          // quadrant angle in radians, Q30
  logic [31:0]        t;           // current series term
  logic signed [33:0] ss, cc;
  logic [3:0]         n;
  logic signed [TW-1:0]    sy, cy, sp, cp;
  logic signed [31:0]      v1;
  logic signed [OFF_W-1:0] off0, off1, off2;

  // shared multiplier and divider
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic                  s_acc;
  logic                  cfg_wr;
  logic                  out_load;
  logic [ANGLE_BITS-1:0] ang;
  logic [31:0]           u;
  logic signed [31:0]    pitch32;
  logic signed [32:0]    p_new;
  logic signed [32:0]    p_clamp;
  logic signed [33:0]    term_v;
  logic [24:0]           s_mag, c_mag;
  logic signed [TW-1:0]  s_pos, c_pos, s_q, c_q;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_gain     <= YAW_GAIN_RST;
      pitch_gain   <= PITCH_GAIN_RST;
      pitch_lower  <= PITCH_LOWER_RST;
      pitch_upper  <= PITCH_UPPER_RST;
      orbit_radius <= ORBIT_RADIUS_RST;
      focus_lift   <= FOCUS_LIFT_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_YAW_GAIN:     yaw_gain     <= pwdata[15:0];
        REG_PITCH_GAIN:   pitch_gain   <= pwdata[15:0];
        REG_PITCH_LOWER:  pitch_lower  <= pwdata[22:0];
        REG_PITCH_UPPER:  pitch_upper  <= pwdata[22:0];
        REG_ORBIT_RADIUS: orbit_radius <= pwdata[15:0];
        REG_FOCUS_LIFT:   focus_lift   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_YAW_GAIN:     prdata = {16'd0, yaw_gain};
      REG_PITCH_GAIN:   prdata = {16'd0, pitch_gain};
      REG_PITCH_LOWER:  prdata = 32'(pitch_lower);
      REG_PITCH_UPPER:  prdata = 32'(pitch_upper);
      REG_ORBIT_RADIUS: prdata = {16'd0, orbit_radius};
      REG_FOCUS_LIFT:   prdata = 32'(focus_lift);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  ocam_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign div_req = '{start: (state == S_TDIV0), dividend: prod[61:30], divisor: n};

  ocam_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // angle under evaluation, as a 32-bit turn fraction
  assign pitch32 = 32'(pitch);
  assign ang     = angle_sel ? pitch32[ANGLE_BITS-1:0] : yaw;
  assign u       = 32'(ang) << (32 - ANGLE_BITS);

  always_comb begin
    case (state)
      S_LOOK_A: begin
        mul_a = 32'(dx);
        mul_b = $signed({16'd0, yaw_gain});
      end
      S_LOOK_B: begin
        mul_a = 32'(dy);
        mul_b = $signed({16'd0, pitch_gain});
      end
      S_TX: begin
        mul_a = $signed({2'b00, u[29:0]});
        mul_b = $signed(PI_HALF_Q30);
      end
      S_TMUL: begin
        mul_a = $signed(t);
        mul_b = $signed(xq);
      end
      S_P1: begin
        mul_a = 32'(sy);
        mul_b = 32'(cp);
      end
      S_P5: begin
        mul_a = 32'(cy);
        mul_b = 32'(cp);
      end
      S_P3, S_P7: begin
        mul_a = v1;
        mul_b = $signed({16'd0, orbit_radius});
      end
      S_P9: begin
        mul_a = 32'(sp);
        mul_b = $signed({16'd0, orbit_radius});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // pitch update with clamp; the lower limit is tested first, so when the limits cross only results below it take it
  assign p_new = 33'(pitch) - $signed(prod[32:0]);
  always_comb begin
    if (p_new < 33'(pitch_lower)) begin
      p_clamp = 33'(pitch_lower);
    end else if (p_new > 33'(pitch_upper)) begin
      p_clamp = 33'(pitch_upper);
    end else begin
      p_clamp = p_new;
    end
  end

  // series term sign follows n: + - - + + - ...
  always_comb begin
    term_v = $signed({2'b00, div_rsp.quot});
    if (n[1]) begin
      term_v = -term_v;
    end
  end

  // quadrant folding
  always_comb begin
    s_mag = to_trig(ss, TRIG_BITS);
    c_mag = to_trig(cc, TRIG_BITS);
    s_pos = $signed(TW'(s_mag));
    c_pos = $signed(TW'(c_mag));
    case (quad)
      2'd0: begin
        s_q = s_pos;
        c_q = c_pos;
      end
      2'd1: begin
        s_q = c_pos;
        c_q = -s_pos;
      end
      2'd2: begin
        s_q = -s_pos;
        c_q = -c_pos;
      end
      default: begin
        s_q = -c_pos;
        c_q = s_pos;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_acc) begin
          state_next = (s_tuser[0] == OP_STEP) ? S_TX : S_LOOK_A;
        end
      end
      S_LOOK_A: state_next = S_LOOK_B;
      S_LOOK_B: state_next = S_LOOK_C;
      S_LOOK_C: state_next = S_OUT;
      S_TX:     state_next = S_TXW;
      S_TXW:    state_next = S_TMUL;
      S_TMUL:   state_next = S_TDIV0;
      S_TDIV0:  state_next = S_TDIV;
      S_TDIV: begin
        if (div_rsp.done) begin
          state_next = (n == TERMS) ? S_TFIN : S_TMUL;
        end
      end
      S_TFIN:   state_next = angle_sel ? S_P1 : S_TX;
      S_P1:     state_next = S_P2;
      S_P2:     state_next = S_P3;
      S_P3:     state_next = S_P4;
      S_P4:     state_next = S_P5;
      S_P5:     state_next = S_P6;
      S_P6:     state_next = S_P7;
      S_P7:     state_next = S_P8;
      S_P8:     state_next = S_P9;
      S_P9:     state_next = S_P10;
      S_P10:    state_next = S_CAM;
      S_CAM:    state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw     <= '0;
      pitch   <= PITCH_RESET;
      focus_x <= '0;
      focus_y <= '0;
      focus_z <= '0;
      cam_x   <= '0;
      cam_y   <= '0;
      cam_z   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc && s_tuser[0] == OP_STEP) begin
            focus_x <= $signed(s_tdata[55:24]);
            focus_y <= sat32(64'($signed(s_tdata[87:56])) + (64'(focus_lift) <<< 8));
            focus_z <= $signed(s_tdata[119:88]);
          end
        end
        S_LOOK_B: yaw   <= yaw + prod[ANGLE_BITS-1:0];
        S_LOOK_C: pitch <= 24'(p_clamp);
        S_CAM: begin
          cam_x <= sat32(64'(focus_x) + 64'(off0));
          cam_y <= sat32(64'(focus_y) + 64'(off1));
          cam_z <= sat32(64'(focus_z) + 64'(off2));
        end
        default: ;
      endcase
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_sel <= 1'b0;
      n         <= 4'd1;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            dx        <= $signed(s_tdata[11:0]);
            dy        <= $signed(s_tdata[23:12]);
            angle_sel <= 1'b0;
          end
        end
        S_TX: quad <= u[31:30];
        S_TXW: begin
          xq <= prod[61:30];
          t  <= 32'd1 << 30;
          ss <= '0;
          cc <= ONE_Q30;
          n  <= 4'd1;
        end
        S_TDIV: begin
          if (div_rsp.done) begin
            t <= div_rsp.quot;
            if (n[0]) begin
              ss <= ss + term_v;
            end else begin
              cc <= cc + term_v;
            end
            n <= n + 4'd1;
          end
        end
        S_TFIN: begin
          if (angle_sel) begin
            sp <= s_q;
            cp <= c_q;
          end else begin
            sy <= s_q;
            cy <= c_q;
          end
          angle_sel <= 1'b1;
        end
        S_P2, S_P6: v1 <= 32'(rnd(prod, TRIG_BITS));
        S_P4:  off0 <= OFF_W'(rnd(prod, TRIG_BITS - 8));
        S_P8:  off2 <= OFF_W'(rnd(prod, TRIG_BITS - 8));
        S_P10: off1 <= OFF_W'(rnd(prod, TRIG_BITS - 8));
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {focus_z, focus_y, focus_x, cam_z, cam_y, cam_x, pitch, 24'(yaw)};
    end
  end

  `OCP_ASSERT(a_one_in_flight, clk, rst, s_acc |=> !s_tready, "word accepted while busy")
  `OCP_ASSERT(a_out_wait, clk, rst, (state == S_OUT && m_tvalid && !m_tready) |=> (state == S_OUT), "result dropped")
  `OCP_ASSERT(a_term_range, clk, rst, (state == S_TDIV) |-> (n != 4'd0 && n <= TERMS), "series term out of range")

endmodule
